// ===== rtl/core/gmra_pkg.sv =====
// ----------------------------------------------------------------------------
// gmra_pkg: shared types and constants of the guest memory region access unit
// Transfer payloads, operation and register codes, region codes and helpers.
// ----------------------------------------------------------------------------
package gmra_pkg;

   localparam int PAGE_BYTES        = 4096;
   localparam int RW_STORE_BYTES    = 65536;
   localparam int RO_STORE_BYTES    = 65536;
   localparam int OUT_STORE_BYTES   = 4096;
   localparam int STACK_STORE_BYTES = 65536;

   localparam int ADDR_W      = 32;
   localparam int DATA_W      = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int NUM_REGIONS = 4;

   localparam logic [2:0] OP_READ       = 3'd0;
   localparam logic [2:0] OP_WRITE      = 3'd1;
   localparam logic [2:0] OP_LOAD_WRITE = 3'd2;
   localparam logic [2:0] OP_SET_HEAP   = 3'd3;
   localparam logic [2:0] OP_RAISE_HEAP = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_RW_BASE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RW_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RO_BASE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RO_LIMIT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_BASE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_LIMIT   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_BASE  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_LIMIT = 3'd7;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOB = 1'b1;

   typedef enum logic [1:0] {
      REGION_RW,
      REGION_RO,
      REGION_OUT,
      REGION_STACK
   } region_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic [1:0]        size_code;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
      logic [ADDR_W-1:0] heap_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              status;
   } rsp_type;

   // window registers; cap is base plus store size, precomputed on write
   typedef struct packed {
      logic [NUM_REGIONS-1:0][ADDR_W-1:0] base;
      logic [NUM_REGIONS-1:0][ADDR_W-1:0] limit;
      logic [NUM_REGIONS-1:0][ADDR_W:0]   cap;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic              write;
      logic [ADDR_W-1:0] offset;
      logic [1:0]        size_code;
      logic [DATA_W-1:0] write_data;
   } acc_type;

   typedef struct packed {
      logic              access;
      logic              write;
      logic              heap_set;
      logic              heap_raise;
      region_type        region;
      logic [ADDR_W-1:0] offset;
      logic              status;
   } dec_type;

   typedef struct packed {
      logic       read;
      region_type region;
      logic [2:0] phase;
      logic [1:0] size_code;
      logic       status;
   } stg_type;

   function automatic logic [3:0] byte_count(input logic [1:0] size_code);
      return 4'd1 << size_code;
   endfunction

endpackage

// ===== rtl/core/gmra_ram.sv =====
// ----------------------------------------------------------------------------
// gmra_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module gmra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gmra_store.sv =====
// ----------------------------------------------------------------------------
// gmra_store: one byte store built from eight byte-lane RAMs
// An unaligned access of up to eight bytes touches each lane at most once,
// so every lane gets its own row address: lanes below the start phase
// use the next row.
// ----------------------------------------------------------------------------
module gmra_store #(
   parameter int BYTES = gmra_pkg::RW_STORE_BYTES,
   parameter int CLR_W = 13
) (
   input  logic                          clock,
   input  logic                          clr_en,
   input  logic [CLR_W-1:0]              clr_row,
   input  gmra_pkg::acc_type             acc,
   output logic [gmra_pkg::DATA_W-1:0]   rd_lanes
);

   localparam int ROWS  = (BYTES + 7) / 8;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [2:0]       phase;
   logic [ROW_W-1:0] row;
   logic [3:0]       count;
   logic             clr_hit;

   assign phase   = acc.offset[2:0];
   assign row     = acc.offset[ROW_W+2:3];
   assign count   = gmra_pkg::byte_count(acc.size_code);
   assign clr_hit = clr_en && (32'(clr_row) < 32'(ROWS));

   for (genvar j = 0; j < 8; j++) begin : g_lane
      logic [2:0]       idx;
      logic             used;
      logic [ROW_W-1:0] lane_row;
      logic             lane_wr_en;
      logic [ROW_W-1:0] lane_wr_addr;
      logic [7:0]       lane_wr_data;

      // byte number within the access that lands in this lane
      assign idx          = 3'(j) - phase;
      assign used         = {1'b0, idx} < count;
      assign lane_row     = (3'(j) < phase) ? row + ROW_W'(1) : row;
      assign lane_wr_en   = clr_hit || (acc.en && acc.write && used);
      assign lane_wr_addr = clr_en ? clr_row[ROW_W-1:0] : lane_row;
      assign lane_wr_data = clr_en ? 8'h00 : acc.write_data[{idx, 3'b000} +: 8];

      gmra_ram #(
         .WIDTH(8),
         .DEPTH(ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (lane_wr_en),
         .wr_addr (lane_wr_addr),
         .wr_data (lane_wr_data),
         .rd_en   (acc.en && !acc.write),
         .rd_addr (lane_row),
         .rd_data (rd_lanes[8*j +: 8])
      );
   end

endmodule

// ===== rtl/core/gmra_heap.sv =====
// ----------------------------------------------------------------------------
// gmra_heap: heap pointer and page-rounded heap end
// For a power-of-two page the end is a mask of the new pointer. Otherwise a
// remainder unit walks the pointer four bits a cycle and reports busy.
// ----------------------------------------------------------------------------
module gmra_heap #(
   parameter int PAGE_BYTES = gmra_pkg::PAGE_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        update,
   input  logic                        set,
   input  logic [gmra_pkg::ADDR_W-1:0] value,
   output logic [gmra_pkg::ADDR_W:0]   heap_bound,
   output logic                        busy
);

   localparam int  AW   = gmra_pkg::ADDR_W;
   localparam bit  POW2 = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;

   logic [AW-1:0] heap_ff;
   logic [AW-1:0] heap_in;

   // raise only moves the pointer up
   always_comb begin
      heap_in = heap_ff;
      if (update && (set || (value > heap_ff))) begin
         heap_in = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= '0;
      end else begin
         heap_ff <= heap_in;
      end
   end

   if (POW2) begin : g_mask
      localparam logic [AW:0] PAGE_MASK = (AW+1)'(PAGE_BYTES - 1);

      logic [AW:0] end_ff;
      logic [AW:0] end_in;

      assign end_in = ({1'b0, heap_in} + PAGE_MASK) & ~PAGE_MASK;

      always_ff @(posedge clock) begin
         if (reset) begin
            end_ff <= '0;
         end else if (update) begin
            end_ff <= end_in;
         end
      end

      assign heap_bound = end_ff;
      assign busy       = 1'b0;
   end else begin : g_rem
      localparam int PAGE_W = $clog2(PAGE_BYTES + 1);
      localparam int DIGITS = 4;
      localparam int STEPS  = AW / DIGITS;
      localparam int CNT_W  = $clog2(STEPS);
      localparam logic [PAGE_W:0] PAGE = (PAGE_W+1)'(PAGE_BYTES);

      typedef enum logic [1:0] {
         IDLE,
         RUN,
         FIX
      } state_type;

      state_type         state_ff;
      logic [AW:0]       end_ff;
      logic [AW-1:0]     num_ff;
      logic [AW-1:0]     num_in;
      logic [PAGE_W-1:0] rem_ff;
      logic [PAGE_W-1:0] rem_in;
      logic [CNT_W-1:0]  cnt_ff;
      logic [AW:0]       pad;

      // restoring remainder, four bits per step
      always_comb begin
         logic [PAGE_W:0]   t;
         logic [PAGE_W-1:0] r;
         logic [AW-1:0]     n;
         r = rem_ff;
         n = num_ff;
         for (int k = 0; k < DIGITS; k++) begin
            t = {r, n[AW-1]};
            n = n << 1;
            if (t >= PAGE) begin
               t = t - PAGE;
            end
            r = t[PAGE_W-1:0];
         end
         rem_in = r;
         num_in = n;
      end

      assign pad = (rem_ff == '0) ? '0 : (AW+1)'(PAGE_BYTES) - (AW+1)'(rem_ff);

      always_ff @(posedge clock) begin
         if (reset) begin
            state_ff <= IDLE;
            end_ff   <= '0;
         end else begin
            case (state_ff)
               IDLE: begin
                  if (update) begin
                     num_ff   <= heap_in;
                     rem_ff   <= '0;
                     cnt_ff   <= '0;
                     state_ff <= RUN;
                  end
               end
               RUN: begin
                  num_ff <= num_in;
                  rem_ff <= rem_in;
                  cnt_ff <= cnt_ff + CNT_W'(1);
                  if (cnt_ff == CNT_W'(STEPS - 1)) begin
                     state_ff <= FIX;
                  end
               end
               FIX: begin
                  end_ff   <= {1'b0, heap_ff} + pad;
                  state_ff <= IDLE;
               end
               default: begin
                  state_ff <= IDLE;
               end
            endcase
         end
      end

      assign heap_bound = end_ff;
      assign busy       = state_ff != IDLE;
   end

endmodule

// ===== rtl/core/gmra_decode.sv =====
// ----------------------------------------------------------------------------
// gmra_decode: region match and bound checks for one item
// Picks the first region in priority order that holds the whole access,
// then checks the store size (and the configured size for read-write).
// ----------------------------------------------------------------------------
module gmra_decode (
   input  gmra_pkg::req_type           req,
   input  gmra_pkg::cfg_type           cfg,
   input  logic [gmra_pkg::ADDR_W:0]   heap_bound,
   output gmra_pkg::dec_type           dec
);

   localparam int AW = gmra_pkg::ADDR_W;

   always_comb begin
      logic [AW:0]          end_addr;
      logic [3:0]           hit;
      logic [3:0]           fit;
      logic                 rw_size_ok;
      logic                 is_access;
      logic                 ok;
      gmra_pkg::region_type region;

      end_addr = {1'b0, req.address} + (AW+1)'(gmra_pkg::byte_count(req.size_code));

      hit[gmra_pkg::REGION_RW]    = (req.address >= cfg.base[gmra_pkg::REGION_RW])
                                    && (end_addr <= heap_bound);
      hit[gmra_pkg::REGION_RO]    = (req.address >= cfg.base[gmra_pkg::REGION_RO])
                                    && (end_addr <= {1'b0, cfg.limit[gmra_pkg::REGION_RO]});
      hit[gmra_pkg::REGION_OUT]   = (req.address >= cfg.base[gmra_pkg::REGION_OUT])
                                    && (end_addr <= {1'b0, cfg.limit[gmra_pkg::REGION_OUT]});
      hit[gmra_pkg::REGION_STACK] = (req.address >= cfg.base[gmra_pkg::REGION_STACK])
                                    && (end_addr <= {1'b0, cfg.limit[gmra_pkg::REGION_STACK]});

      for (int r = 0; r < gmra_pkg::NUM_REGIONS; r++) begin
         fit[r] = end_addr <= cfg.cap[r];
      end

      // offset + n <= limit - base, with an empty window when limit <= base
      rw_size_ok = (cfg.limit[gmra_pkg::REGION_RW] > cfg.base[gmra_pkg::REGION_RW])
                   && (end_addr <= {1'b0, cfg.limit[gmra_pkg::REGION_RW]});

      is_access = (req.operation == gmra_pkg::OP_READ)
                  || (req.operation == gmra_pkg::OP_WRITE)
                  || (req.operation == gmra_pkg::OP_LOAD_WRITE);

      region = gmra_pkg::REGION_RW;
      ok     = 1'b0;
      if (hit[gmra_pkg::REGION_RW]) begin
         region = gmra_pkg::REGION_RW;
         ok     = rw_size_ok && fit[gmra_pkg::REGION_RW];
      end else if ((req.operation == gmra_pkg::OP_READ) && hit[gmra_pkg::REGION_RO]) begin
         region = gmra_pkg::REGION_RO;
         ok     = fit[gmra_pkg::REGION_RO];
      end else if (hit[gmra_pkg::REGION_OUT]) begin
         region = gmra_pkg::REGION_OUT;
         ok     = fit[gmra_pkg::REGION_OUT];
      end else if (hit[gmra_pkg::REGION_STACK]) begin
         region = gmra_pkg::REGION_STACK;
         ok     = fit[gmra_pkg::REGION_STACK];
      end else if ((req.operation == gmra_pkg::OP_LOAD_WRITE) && hit[gmra_pkg::REGION_RO]) begin
         region = gmra_pkg::REGION_RO;
         ok     = fit[gmra_pkg::REGION_RO];
      end

      dec.access     = is_access && ok;
      dec.write      = req.operation != gmra_pkg::OP_READ;
      dec.heap_set   = req.operation == gmra_pkg::OP_SET_HEAP;
      dec.heap_raise = req.operation == gmra_pkg::OP_RAISE_HEAP;
      dec.region     = region;
      dec.offset     = req.address - cfg.base[region];
      if (is_access) begin
         dec.status = ok ? gmra_pkg::STATUS_OK : gmra_pkg::STATUS_OOB;
      end else if (dec.heap_set || dec.heap_raise) begin
         dec.status = gmra_pkg::STATUS_OK;
      end else begin
         dec.status = gmra_pkg::STATUS_OOB;
      end
   end

endmodule

// ===== rtl/core/guest_memory_region_access_top.sv =====
// ----------------------------------------------------------------------------
// guest_memory_region_access_top: guest memory region access unit
// Loads, stores and heap pointer updates against four windowed byte stores.
//
// Usage:
//   req_* carries one access or heap update per transfer; rsp_* returns
//   exactly one result per request, in order. csr_* writes the eight window
//   registers (base/limit pairs); the user must write them only while the
//   unit is idle, which the unit does not enforce. Decode and store access
//   run from the input register, then read-lane assembly fills the result
//   register. One request per cycle is taken while nothing stalls it. With
//   a power-of-two page a heap update costs nothing extra; otherwise the
//   page remainder unit holds the next request while busy after a heap
//   update. After reset the stores are zeroed by a clearing pass of one row
//   per cycle over max(store bytes / 8) rows (8192 rows by default);
//   req_stall is high during that pass while csr writes are taken.
//   When rsp_stall is high the result holds; the input register and the
//   store read stage keep filling, and req_stall rises once both are full.
// ----------------------------------------------------------------------------
module guest_memory_region_access_top #(
   parameter int PAGE_BYTES        = gmra_pkg::PAGE_BYTES,
   parameter int RW_STORE_BYTES    = gmra_pkg::RW_STORE_BYTES,
   parameter int RO_STORE_BYTES    = gmra_pkg::RO_STORE_BYTES,
   parameter int OUT_STORE_BYTES   = gmra_pkg::OUT_STORE_BYTES,
   parameter int STACK_STORE_BYTES = gmra_pkg::STACK_STORE_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gmra_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gmra_pkg::rsp_type                rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [gmra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gmra_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int AW         = gmra_pkg::ADDR_W;
   localparam int DW         = gmra_pkg::DATA_W;
   localparam int RW_ROWS    = (RW_STORE_BYTES + 7) / 8;
   localparam int RO_ROWS    = (RO_STORE_BYTES + 7) / 8;
   localparam int OUT_ROWS   = (OUT_STORE_BYTES + 7) / 8;
   localparam int STACK_ROWS = (STACK_STORE_BYTES + 7) / 8;
   localparam int MAX_A      = (RW_ROWS > RO_ROWS) ? RW_ROWS : RO_ROWS;
   localparam int MAX_B      = (OUT_ROWS > STACK_ROWS) ? OUT_ROWS : STACK_ROWS;
   localparam int MAX_ROWS   = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int CLR_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // ---------------- configuration ----------------
   gmra_pkg::cfg_type cfg_ff;
   gmra_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gmra_pkg::CSR_RW_BASE: begin
               cfg_in.base[gmra_pkg::REGION_RW] = csr_wr_data;
               cfg_in.cap[gmra_pkg::REGION_RW]  = {1'b0, csr_wr_data}
                                                  + (AW+1)'(RW_STORE_BYTES);
            end
            gmra_pkg::CSR_RW_LIMIT: begin
               cfg_in.limit[gmra_pkg::REGION_RW] = csr_wr_data;
            end
            gmra_pkg::CSR_RO_BASE: begin
               cfg_in.base[gmra_pkg::REGION_RO] = csr_wr_data;
               cfg_in.cap[gmra_pkg::REGION_RO]  = {1'b0, csr_wr_data}
                                                  + (AW+1)'(RO_STORE_BYTES);
            end
            gmra_pkg::CSR_RO_LIMIT: begin
               cfg_in.limit[gmra_pkg::REGION_RO] = csr_wr_data;
            end
            gmra_pkg::CSR_OUT_BASE: begin
               cfg_in.base[gmra_pkg::REGION_OUT] = csr_wr_data;
               cfg_in.cap[gmra_pkg::REGION_OUT]  = {1'b0, csr_wr_data}
                                                   + (AW+1)'(OUT_STORE_BYTES);
            end
            gmra_pkg::CSR_OUT_LIMIT: begin
               cfg_in.limit[gmra_pkg::REGION_OUT] = csr_wr_data;
            end
            gmra_pkg::CSR_STACK_BASE: begin
               cfg_in.base[gmra_pkg::REGION_STACK] = csr_wr_data;
               cfg_in.cap[gmra_pkg::REGION_STACK]  = {1'b0, csr_wr_data}
                                                     + (AW+1)'(STACK_STORE_BYTES);
            end
            gmra_pkg::CSR_STACK_LIMIT: begin
               cfg_in.limit[gmra_pkg::REGION_STACK] = csr_wr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base                         <= '0;
         cfg_ff.limit                        <= '0;
         cfg_ff.cap[gmra_pkg::REGION_RW]    <= (AW+1)'(RW_STORE_BYTES);
         cfg_ff.cap[gmra_pkg::REGION_RO]    <= (AW+1)'(RO_STORE_BYTES);
         cfg_ff.cap[gmra_pkg::REGION_OUT]   <= (AW+1)'(OUT_STORE_BYTES);
         cfg_ff.cap[gmra_pkg::REGION_STACK] <= (AW+1)'(STACK_STORE_BYTES);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- clearing pass ----------------
   logic             clear_ff;
   logic             clear_in;
   logic [CLR_W-1:0] clr_row_ff;
   logic [CLR_W-1:0] clr_row_in;

   assign clear_in   = clear_ff && (clr_row_ff != CLR_W'(MAX_ROWS - 1));
   assign clr_row_in = clear_ff ? clr_row_ff + CLR_W'(1) : clr_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_row_ff <= '0;
      end else begin
         clear_ff   <= clear_in;
         clr_row_ff <= clr_row_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic              s1_valid_ff;
   logic              s1_valid_in;
   gmra_pkg::req_type s1_req_ff;
   logic              s2_valid_ff;
   gmra_pkg::stg_type s2_ff;
   gmra_pkg::stg_type s2_in;
   logic              rsp_valid_ff;
   gmra_pkg::rsp_type rsp_ff;
   gmra_pkg::rsp_type rsp_in;
   logic              en2;
   logic              en3;
   logic              proc;
   logic              accept;
   logic              heap_busy;
   logic [AW:0]       heap_bound;
   gmra_pkg::dec_type dec;

   assign en3       = !rsp_valid_ff || !rsp_stall;
   assign en2       = !s2_valid_ff || en3;
   assign proc      = s1_valid_ff && en2 && !heap_busy;
   assign req_stall = clear_ff || (s1_valid_ff && !proc);
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in = accept || (s1_valid_ff && !proc);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (en2) begin
            s2_valid_ff <= proc;
         end
         if (en3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_payload;
      end
      if (proc) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------- decode and heap ----------------
   gmra_decode u_decode (
      .req        (s1_req_ff),
      .cfg        (cfg_ff),
      .heap_bound (heap_bound),
      .dec        (dec)
   );

   gmra_heap #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_heap (
      .clock      (clock),
      .reset      (reset),
      .update     (proc && (dec.heap_set || dec.heap_raise)),
      .set        (dec.heap_set),
      .value      (s1_req_ff.heap_value),
      .heap_bound (heap_bound),
      .busy       (heap_busy)
   );

   assign s2_in.read      = dec.access && (s1_req_ff.operation == gmra_pkg::OP_READ);
   assign s2_in.region    = dec.region;
   assign s2_in.phase     = dec.offset[2:0];
   assign s2_in.size_code = s1_req_ff.size_code;
   assign s2_in.status    = dec.status;

   // ---------------- stores ----------------
   gmra_pkg::acc_type acc_rw;
   gmra_pkg::acc_type acc_ro;
   gmra_pkg::acc_type acc_out;
   gmra_pkg::acc_type acc_stack;
   gmra_pkg::acc_type acc_any;
   logic [DW-1:0]     lanes_rw;
   logic [DW-1:0]     lanes_ro;
   logic [DW-1:0]     lanes_out;
   logic [DW-1:0]     lanes_stack;

   assign acc_any.en         = proc && dec.access;
   assign acc_any.write      = dec.write;
   assign acc_any.offset     = dec.offset;
   assign acc_any.size_code  = s1_req_ff.size_code;
   assign acc_any.write_data = s1_req_ff.write_data;

   always_comb begin
      acc_rw       = acc_any;
      acc_ro       = acc_any;
      acc_out      = acc_any;
      acc_stack    = acc_any;
      acc_rw.en    = acc_any.en && (dec.region == gmra_pkg::REGION_RW);
      acc_ro.en    = acc_any.en && (dec.region == gmra_pkg::REGION_RO);
      acc_out.en   = acc_any.en && (dec.region == gmra_pkg::REGION_OUT);
      acc_stack.en = acc_any.en && (dec.region == gmra_pkg::REGION_STACK);
   end

   gmra_store #(.BYTES(RW_STORE_BYTES), .CLR_W(CLR_W)) u_rw_store (
      .clock    (clock),
      .clr_en   (clear_ff),
      .clr_row  (clr_row_ff),
      .acc      (acc_rw),
      .rd_lanes (lanes_rw)
   );

   gmra_store #(.BYTES(RO_STORE_BYTES), .CLR_W(CLR_W)) u_ro_store (
      .clock    (clock),
      .clr_en   (clear_ff),
      .clr_row  (clr_row_ff),
      .acc      (acc_ro),
      .rd_lanes (lanes_ro)
   );

   gmra_store #(.BYTES(OUT_STORE_BYTES), .CLR_W(CLR_W)) u_out_store (
      .clock    (clock),
      .clr_en   (clear_ff),
      .clr_row  (clr_row_ff),
      .acc      (acc_out),
      .rd_lanes (lanes_out)
   );

   gmra_store #(.BYTES(STACK_STORE_BYTES), .CLR_W(CLR_W)) u_stack_store (
      .clock    (clock),
      .clr_en   (clear_ff),
      .clr_row  (clr_row_ff),
      .acc      (acc_stack),
      .rd_lanes (lanes_stack)
   );

   // ---------------- read assembly ----------------
   always_comb begin
      logic [DW-1:0] lanes;
      logic [DW-1:0] value;
      logic [2:0]    src;
      case (s2_ff.region)
         gmra_pkg::REGION_RW:    lanes = lanes_rw;
         gmra_pkg::REGION_RO:    lanes = lanes_ro;
         gmra_pkg::REGION_OUT:   lanes = lanes_out;
         gmra_pkg::REGION_STACK: lanes = lanes_stack;
         default:                lanes = lanes_rw;
      endcase
      // rotate lanes back into little-endian byte order
      for (int i = 0; i < 8; i++) begin
         src = 3'(i) + s2_ff.phase;
         if (4'(i) < gmra_pkg::byte_count(s2_ff.size_code)) begin
            value[8*i +: 8] = lanes[{src, 3'b000} +: 8];
         end else begin
            value[8*i +: 8] = 8'h00;
         end
      end
      rsp_in.read_data = s2_ff.read ? value : '0;
      rsp_in.status    = s2_ff.status;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- assertions ----------------
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == gmra_pkg::STATUS_OOB))
      |-> (rsp_payload.read_data == '0))
      else $error("out-of-bounds result carries read data");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({acc_rw.en, acc_ro.en, acc_out.en, acc_stack.en}))
      else $error("more than one store accessed in a cycle");

   assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !(acc_rw.en || acc_ro.en || acc_out.en || acc_stack.en))
      else $error("store access during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      !clear_ff |=> !clear_ff)
      else $error("clearing pass restarted outside reset");

endmodule
